/* hdl/bffa_pkg.sv */
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared widths, codes and control structs of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int DEF_BLOCK_ENTRIES = 1024;
  localparam int DEF_INODE_ENTRIES = 128;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int RSV_W   = 11;
  localparam int STAT_W  = 2;
  localparam int WORD_W  = 32;
  localparam int WORD_AW = $clog2(WORD_W);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_e;

  typedef struct packed {
    logic    load;
    logic    read;
    logic    advance;
    logic    take;
    logic    write;
    logic    sweep;
    logic    mark;
    logic    load_counts;
    logic    set_status;
    status_e code;
    logic    push;
  } bffa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_init;
    logic pool_full;
    logic idx_oor;
    logic hit;
    logic last_word;
    logic sweep_last;
    logic rsp_free;
  } bffa_stat_t;

endpackage

/* hdl/bffa_if.sv */
// ----------------------------------------------------------------------------
// bffa channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface bffa_req_if import bffa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic             pool;
  logic [IDX_W-1:0] index;

  modport source (output valid, output op, output pool, output index, input ready);
  modport sink   (input valid, input op, input pool, input index, output ready);
endinterface

interface bffa_rsp_if import bffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  granted_index;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, output status, output granted_index, output free_count,
                  input ready);
  modport sink   (input valid, input status, input granted_index, input free_count,
                  output ready);
endinterface

interface bffa_cfg_if import bffa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RSV_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/bitmap_first_fit_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_unit
// Two-pool bitmap allocator: first-fit allocate, free and init requests.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  req_i    in   valid/ready  op, pool, index
//  rsp_o    out  valid/ready  status, granted_index, free_count
//  cfg_i    in   valid/ready  data (reserved_blocks), ready held high
//
//  Bitmaps live in 32-bit word memories, scanned one word per cycle.
//  An allocate scans from the first unreserved word and answers full after the
//  last word, or without a scan when the whole block pool is reserved.
//  A free reads the indexed word; init sweeps every word of both bitmaps.
//  After reset a clearing sweep holds req_i.ready low.
//  One request at a time; a stalled response holds and blocks the next response.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_unit import bffa_pkg::*; #(
  parameter int BLOCK_ENTRIES = DEF_BLOCK_ENTRIES,
  parameter int INODE_ENTRIES = DEF_INODE_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bffa_req_if.sink          req_i,
  bffa_rsp_if.source        rsp_o,
  bffa_cfg_if.sink          cfg_i
);

  bffa_cmd_t  cmd;
  bffa_stat_t stat;

  assign cfg_i.ready = 1'b1;

  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  bffa_datapath #(
    .BLOCK_ENTRIES (BLOCK_ENTRIES),
    .INODE_ENTRIES (INODE_ENTRIES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_op_i            (req_i.op),
    .req_pool_i          (req_i.pool),
    .req_index_i         (req_i.index),
    .cfg_valid_i         (cfg_i.valid),
    .cfg_data_i          (cfg_i.data),
    .rsp_valid_o         (rsp_o.valid),
    .rsp_ready_i         (rsp_o.ready),
    .rsp_status_o        (rsp_o.status),
    .rsp_granted_index_o (rsp_o.granted_index),
    .rsp_free_count_o    (rsp_o.free_count),
    .cmd_i               (cmd),
    .stat_o              (stat)
  );

endmodule

/* hdl/bffa_ctrl.sv */
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer: clearing sweep, request decode, word scan, write back, response.
// ----------------------------------------------------------------------------
module bffa_ctrl import bffa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  output bffa_cmd_t  cmd_o,
  input  bffa_stat_t stat_i
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_READ   = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_WRITE  = 8'b0010_0000,
    S_INIT   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_init) begin
          state_d = S_INIT;
        end else if (stat_i.is_alloc) begin
          if (stat_i.pool_full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.code       = ST_FULL;
            state_d          = S_RESP;
          end else begin
            state_d = S_READ;
          end
        end else if (stat_i.is_free) begin
          if (stat_i.idx_oor) begin
            cmd_o.set_status = 1'b1;
            cmd_o.code       = ST_RANGE;
            state_d          = S_RESP;
          end else begin
            state_d = S_READ;
          end
        end else begin
          state_d = S_RESP;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.take = 1'b1;
          state_d    = S_WRITE;
        end else if (stat_i.is_free) begin
          cmd_o.set_status = 1'b1;
          cmd_o.code       = ST_FREE;
          state_d          = S_RESP;
        end else if (stat_i.last_word) begin
          cmd_o.set_status = 1'b1;
          cmd_o.code       = ST_FULL;
          state_d          = S_RESP;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = S_RESP;
      end
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        cmd_o.mark  = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.load_counts = 1'b1;
          state_d           = S_RESP;
        end
      end
      S_RESP: begin
        if (stat_i.rsp_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/bffa_datapath.sv */
// ----------------------------------------------------------------------------
// bffa_datapath
// Bitmap word memories, scan address, first-fit encoder, counters, result reg.
// ----------------------------------------------------------------------------
module bffa_datapath import bffa_pkg::*; #(
  parameter int BLOCK_ENTRIES = DEF_BLOCK_ENTRIES,
  parameter int INODE_ENTRIES = DEF_INODE_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OP_W-1:0]   req_op_i,
  input  logic              req_pool_i,
  input  logic [IDX_W-1:0]  req_index_i,
  input  logic              cfg_valid_i,
  input  logic [RSV_W-1:0]  cfg_data_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output logic [STAT_W-1:0] rsp_status_o,
  output logic [IDX_W-1:0]  rsp_granted_index_o,
  output logic [CNT_W-1:0]  rsp_free_count_o,
  input  bffa_cmd_t         cmd_i,
  output bffa_stat_t        stat_o
);

  localparam int BW    = (BLOCK_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int IW    = (INODE_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int SW    = (BW > IW) ? BW : IW;
  localparam int AW    = (SW > 1) ? $clog2(SW) : 1;
  localparam int BAW   = (BW > 1) ? $clog2(BW) : 1;
  localparam int IAW   = (IW > 1) ? $clog2(IW) : 1;
  localparam int PW    = AW + WORD_AW + 1;
  localparam int LW    = (PW > RSV_W) ? PW : RSV_W;
  localparam int BCW   = $clog2(BLOCK_ENTRIES + 1);
  localparam int ICW   = $clog2(INODE_ENTRIES + 1);

  logic [WORD_W-1:0] blk_mem_q [BW];
  logic [WORD_W-1:0] ino_mem_q [IW];
  logic [WORD_W-1:0] blk_rdata_q, ino_rdata_q;

  logic [RSV_W-1:0]   reserved_q;
  logic [BCW-1:0]     blk_cnt_q;
  logic [ICW-1:0]     ino_cnt_q;
  logic [AW-1:0]      scan_q;
  logic               rsp_valid_q;
  op_e                op_q;
  logic               pool_q;
  logic [IDX_W-1:0]   idx_q;
  logic [WORD_AW-1:0] bitpos_q;
  status_e            status_q;
  logic [IDX_W-1:0]   granted_q;
  logic [STAT_W-1:0]  rsp_status_q;
  logic [IDX_W-1:0]   rsp_granted_q;
  logic [CNT_W-1:0]   rsp_count_q;

  logic [LW-1:0]      rsv_ext, lim_ext;
  logic [PW-1:0]      limit, start_pos, size_pos;
  logic [AW-1:0]      rd_addr, scan_d;
  logic [WORD_W-1:0]  rword, cand, sweep_mask, bit_sel, mod_word;
  logic [WORD_AW-1:0] hit_pos;
  logic               is_alloc, blk_re, ino_re, blk_we, ino_we;
  logic [CNT_W-1:0]   count_sel;

  assign rsv_ext = LW'(reserved_q);
  assign lim_ext = (rsv_ext > LW'(BLOCK_ENTRIES)) ? LW'(BLOCK_ENTRIES) : rsv_ext;
  assign limit   = PW'(lim_ext);

  assign is_alloc  = (op_q == OP_ALLOC);
  assign start_pos = pool_q ? '0 : limit;
  assign size_pos  = pool_q ? PW'(INODE_ENTRIES) : PW'(BLOCK_ENTRIES);
  assign rword     = pool_q ? ino_rdata_q : blk_rdata_q;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = !rword[b]
                && (PW'({scan_q, WORD_AW'(b)}) >= start_pos)
                && (PW'({scan_q, WORD_AW'(b)}) < size_pos);
      sweep_mask[b] = cmd_i.mark && (PW'({scan_q, WORD_AW'(b)}) < limit);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) hit_pos = WORD_AW'(b);
    end
  end

  assign bit_sel  = WORD_W'(1) << bitpos_q;
  assign mod_word = is_alloc ? (rword | bit_sel) : (rword & ~bit_sel);

  assign rd_addr = cmd_i.advance ? scan_q + 1'b1 : scan_q;
  assign blk_re  = (cmd_i.read || cmd_i.advance) && !pool_q;
  assign ino_re  = (cmd_i.read || cmd_i.advance) && pool_q;
  assign blk_we  = (cmd_i.write && !pool_q) || (cmd_i.sweep && (32'(scan_q) < 32'(BW)));
  assign ino_we  = (cmd_i.write && pool_q) || (cmd_i.sweep && (32'(scan_q) < 32'(IW)));

  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem_q[scan_q[BAW-1:0]] <= cmd_i.sweep ? sweep_mask : mod_word;
    if (blk_re) blk_rdata_q <= blk_mem_q[rd_addr[BAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ino_we) ino_mem_q[scan_q[IAW-1:0]] <= cmd_i.sweep ? '0 : mod_word;
    if (ino_re) ino_rdata_q <= ino_mem_q[rd_addr[IAW-1:0]];
  end

  always_comb begin
    scan_d = scan_q;
    if (cmd_i.load) begin
      if (op_e'(req_op_i) == OP_FREE) begin
        scan_d = AW'(req_index_i[IDX_W-1:WORD_AW]);
      end else if (op_e'(req_op_i) == OP_ALLOC && !req_pool_i) begin
        scan_d = AW'(limit[PW-1:WORD_AW]);
      end else begin
        scan_d = '0;
      end
    end else if (cmd_i.advance || cmd_i.sweep) begin
      scan_d = scan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q  <= '0;
      blk_cnt_q   <= BCW'(BLOCK_ENTRIES);
      ino_cnt_q   <= ICW'(INODE_ENTRIES);
      scan_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) reserved_q <= cfg_data_i;
      scan_q <= scan_d;
      if (cmd_i.load_counts) begin
        blk_cnt_q <= BCW'(PW'(BLOCK_ENTRIES) - limit);
        ino_cnt_q <= ICW'(INODE_ENTRIES);
      end else if (cmd_i.write) begin
        if (pool_q) begin
          if (is_alloc && ino_cnt_q != '0) begin
            ino_cnt_q <= ino_cnt_q - 1'b1;
          end else if (!is_alloc && ino_cnt_q != ICW'(INODE_ENTRIES)) begin
            ino_cnt_q <= ino_cnt_q + 1'b1;
          end
        end else begin
          if (is_alloc && blk_cnt_q != '0) begin
            blk_cnt_q <= blk_cnt_q - 1'b1;
          end else if (!is_alloc && blk_cnt_q != BCW'(BLOCK_ENTRIES)) begin
            blk_cnt_q <= blk_cnt_q + 1'b1;
          end
        end
      end
      if (cmd_i.push) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign count_sel = pool_q ? CNT_W'(ino_cnt_q) : CNT_W'(blk_cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_e'(req_op_i);
      pool_q    <= req_pool_i;
      idx_q     <= req_index_i;
      bitpos_q  <= req_index_i[WORD_AW-1:0];
      status_q  <= ST_DONE;
      granted_q <= '0;
    end
    if (cmd_i.set_status) status_q <= cmd_i.code;
    if (cmd_i.take && is_alloc) bitpos_q <= hit_pos;
    if (cmd_i.write && is_alloc) granted_q <= IDX_W'({scan_q, bitpos_q});
    if (cmd_i.push) begin
      rsp_status_q  <= status_q;
      rsp_granted_q <= granted_q;
      rsp_count_q   <= count_sel;
    end
  end

  assign rsp_valid_o         = rsp_valid_q;
  assign rsp_status_o        = rsp_status_q;
  assign rsp_granted_index_o = rsp_granted_q;
  assign rsp_free_count_o    = rsp_count_q;

  assign stat_o.is_alloc   = is_alloc;
  assign stat_o.is_free    = (op_q == OP_FREE);
  assign stat_o.is_init    = (op_q == OP_INIT);
  assign stat_o.pool_full  = !pool_q && (limit == PW'(BLOCK_ENTRIES));
  assign stat_o.idx_oor    = pool_q ? (32'(idx_q) >= 32'(INODE_ENTRIES))
                                    : (32'(idx_q) >= 32'(BLOCK_ENTRIES));
  assign stat_o.hit        = is_alloc ? (|cand) : rword[bitpos_q];
  assign stat_o.last_word  = pool_q ? (scan_q == AW'(IW - 1)) : (scan_q == AW'(BW - 1));
  assign stat_o.sweep_last = (scan_q == AW'(SW - 1));
  assign stat_o.rsp_free   = !rsp_valid_q || rsp_ready_i;

endmodule

/* hdl/bffa_checker.sv */
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bffa_checker import bffa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [STAT_W-1:0] rsp_status_i,
  input logic [IDX_W-1:0]  rsp_granted_index_i,
  input logic [CNT_W-1:0]  rsp_free_count_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_granted_index_i) && $stable(rsp_free_count_i))
    else $error("response word changed while stalled");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_DONE) |-> rsp_granted_index_i == '0)
    else $error("index granted with a failing status");

  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !req_ready_i)
    else $error("request taken during the clearing sweep");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second request taken while one is in work");

endmodule

bind bitmap_first_fit_allocator_unit bffa_checker u_bffa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_status_i        (rsp_o.status),
  .rsp_granted_index_i (rsp_o.granted_index),
  .rsp_free_count_i    (rsp_o.free_count)
);
